### hw/rtl/skhc_pkg.sv
`timescale 1ns / 1ps
package skhc_pkg;

   // opcodes
   localparam logic [1:0] OP_MARK   = 2'd0;
   localparam logic [1:0] OP_UNMARK = 2'd1;
   localparam logic [1:0] OP_COUNT  = 2'd2;
   localparam logic [1:0] OP_NOP    = 2'd3;

   // result status codes
   localparam logic [1:0] ST_DONE   = 2'd0;
   localparam logic [1:0] ST_FULL   = 2'd1;
   localparam logic [1:0] ST_ABSENT = 2'd2;

   // slot modes
   localparam logic [1:0] MODE_EMPTY = 2'd0;
   localparam logic [1:0] MODE_LIVE  = 2'd1;
   localparam logic [1:0] MODE_TOMB  = 2'd2;

   localparam int KEY_LEN_W = 5;
   localparam int COUNT_W   = 31;
   localparam int HASH_W    = 64;
   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;

   // fnv prime 0x100000001b3 = 1 + 2 + 16 + 32 + 128 + 256 + 2^40
   // the unit term is the starting value, the rest are added one per cycle
   localparam int MUL_TERMS = 6;
   localparam int MUL_SHIFT [MUL_TERMS] = '{1, 4, 5, 7, 8, 40};

   typedef enum logic [1:0] {
      HS_IDLE,
      HS_XOR,
      HS_MUL,
      HS_MOD
   } hash_state_type;

   typedef enum logic [2:0] {
      TS_CLEAR,
      TS_IDLE,
      TS_HASH,
      TS_READ,
      TS_CHECK,
      TS_RESP
   } top_state_type;

endpackage

### hw/rtl/string_key_counting_hash_table_unit.sv
`timescale 1ns / 1ps
// Counting hash table for byte-string keys of up to MAX_KEY_BYTES bytes held in
// TABLE_SLOTS slots. Each request beat marks (insert or increment, saturating),
// unmarks (leaves a tombstone) or queries a key and gives one response beat with
// a status and a count. The home slot is FNV-1a 64 of the key modulo TABLE_SLOTS,
// then a linear probe skips tombstones. After reset the unit sweeps the slot
// memory, one slot per cycle, and stalls requests until the sweep ends. One
// request at a time: for each key byte the hash folds the byte in, then the
// prime multiply adds one shifted term per cycle; the modulo takes one hash
// bit per cycle, and each probed slot is read on the memory read port and then
// checked. A no-op or a mark refused by the load limit skips the hash and the
// lookup and goes straight to the response. A new request is taken while the
// previous response still waits in the output register. A mark is refused once
// the live count would pass three quarters of the slots, or when a full wrap
// finds no empty slot.
module string_key_counting_hash_table_unit #(
   parameter int TABLE_SLOTS   = 64,
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_opcode,
   input  logic [63:0]                         req_key_low_bytes,
   input  logic [63:0]                         req_key_high_bytes,
   input  logic [skhc_pkg::KEY_LEN_W-1:0]      req_key_length,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [1:0]                          rsp_status,
   output logic [skhc_pkg::COUNT_W-1:0]        rsp_hit_count
);

   localparam int KEY_W      = 8 * MAX_KEY_BYTES;
   localparam int IDX_W      = $clog2(TABLE_SLOTS);
   localparam int LIVE_W     = $clog2(TABLE_SLOTS + 1);
   localparam int LOAD_LIMIT = (3 * TABLE_SLOTS) / 4;
   // slot word: mode, count, length, key
   localparam int KEY_LSB    = 0;
   localparam int LEN_LSB    = KEY_W;
   localparam int CNT_LSB    = LEN_LSB + skhc_pkg::KEY_LEN_W;
   localparam int MODE_LSB   = CNT_LSB + skhc_pkg::COUNT_W;
   localparam int ENTRY_W    = MODE_LSB + 2;

   skhc_pkg::top_state_type ts_ff, ts_in;

   logic [1:0]                        op_ff;
   logic [KEY_W-1:0]                  key_ff;
   logic [skhc_pkg::KEY_LEN_W-1:0]    len_ff;
   logic [IDX_W-1:0]                  idx_ff;   // probe slot, also sweep pointer
   logic [IDX_W-1:0]                  probe_ff; // slots visited so far
   logic [LIVE_W-1:0]                 live_ff;
   logic [1:0]                        res_status_ff;
   logic [skhc_pkg::COUNT_W-1:0]      res_hit_ff;
   logic                              rsp_valid_ff;
   logic [1:0]                        rsp_status_ff;
   logic [skhc_pkg::COUNT_W-1:0]      rsp_hit_ff;

   // request key cut to the effective length
   logic [127:0]                      raw_key;
   logic [skhc_pkg::KEY_LEN_W-1:0]    len_eff;
   logic [KEY_W-1:0]                  key_masked;

   logic                              accept;
   logic                              quick;    // answered without a lookup
   logic                              hash_start;
   logic                              hash_done;
   logic [IDX_W-1:0]                  hash_home;

   logic                              wr_en;
   logic [IDX_W-1:0]                  wr_addr;
   logic [ENTRY_W-1:0]                wr_data;
   logic [ENTRY_W-1:0]                rd_data;

   logic [1:0]                        rd_mode;
   logic [skhc_pkg::COUNT_W-1:0]      rd_count;
   logic [skhc_pkg::COUNT_W-1:0]      inc_count;
   logic                              match;
   logic                              found;
   logic                              stop_empty;
   logic                              wrapped;
   logic [IDX_W-1:0]                  idx_next;
   logic                              out_free;

   assign raw_key = {req_key_high_bytes, req_key_low_bytes};
   assign len_eff = (req_key_length > skhc_pkg::KEY_LEN_W'(MAX_KEY_BYTES))
                    ? skhc_pkg::KEY_LEN_W'(MAX_KEY_BYTES) : req_key_length;

   always_comb begin
      for (int i = 0; i < MAX_KEY_BYTES; i++) begin
         key_masked[8*i +: 8] = (skhc_pkg::KEY_LEN_W'(i) < len_eff)
                                ? raw_key[8*i +: 8] : 8'h00;
      end
   end

   assign accept = (ts_ff == skhc_pkg::TS_IDLE) && req_valid;
   // no-op, or a mark over the load limit, goes straight to the response
   assign quick  = (req_opcode == skhc_pkg::OP_NOP) ||
                   ((req_opcode == skhc_pkg::OP_MARK) && (live_ff >= LIVE_W'(LOAD_LIMIT)));
   assign hash_start = accept && !quick;

   skhc_hash #(
      .TABLE_SLOTS   (TABLE_SLOTS),
      .MAX_KEY_BYTES (MAX_KEY_BYTES)
   ) u_hash (
      .clock      (clock),
      .reset      (reset),
      .start      (hash_start),
      .key        (key_masked),
      .key_length (len_eff),
      .done       (hash_done),
      .home       (hash_home)
   );

   skhc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_SLOTS)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // slot inspection, valid in the check state
   assign rd_mode    = rd_data[MODE_LSB +: 2];
   assign rd_count   = rd_data[CNT_LSB +: skhc_pkg::COUNT_W];
   assign inc_count  = (rd_count == skhc_pkg::COUNT_MAX) ? rd_count : rd_count + 1'b1;
   assign match      = (rd_mode == skhc_pkg::MODE_LIVE) &&
                       (rd_data[LEN_LSB +: skhc_pkg::KEY_LEN_W] == len_ff) &&
                       (rd_data[KEY_LSB +: KEY_W] == key_ff);
   // any mode other than live or tombstone ends the probe as empty
   assign stop_empty = (rd_mode != skhc_pkg::MODE_LIVE) && (rd_mode != skhc_pkg::MODE_TOMB);
   assign found      = match;
   assign wrapped    = (probe_ff == IDX_W'(TABLE_SLOTS - 1));
   assign idx_next   = (idx_ff == IDX_W'(TABLE_SLOTS - 1)) ? '0 : idx_ff + 1'b1;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      ts_in = ts_ff;
      case (ts_ff)
         skhc_pkg::TS_CLEAR: begin
            if (idx_ff == IDX_W'(TABLE_SLOTS - 1)) ts_in = skhc_pkg::TS_IDLE;
         end
         skhc_pkg::TS_IDLE: begin
            if (accept) ts_in = quick ? skhc_pkg::TS_RESP : skhc_pkg::TS_HASH;
         end
         skhc_pkg::TS_HASH: if (hash_done) ts_in = skhc_pkg::TS_READ;
         skhc_pkg::TS_READ: ts_in = skhc_pkg::TS_CHECK;
         skhc_pkg::TS_CHECK: begin
            if (found || stop_empty || wrapped) ts_in = skhc_pkg::TS_RESP;
            else ts_in = skhc_pkg::TS_READ;
         end
         skhc_pkg::TS_RESP: if (out_free) ts_in = skhc_pkg::TS_IDLE;
         default: ts_in = skhc_pkg::TS_CLEAR;
      endcase
   end

   // memory writes and request stall
   always_comb begin
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = rd_data;
      req_stall = 1'b1;
      case (ts_ff)
         skhc_pkg::TS_CLEAR: begin
            // sweep every slot to empty
            wr_en   = 1'b1;
            wr_data = '0;
         end
         skhc_pkg::TS_IDLE: req_stall = 1'b0;
         skhc_pkg::TS_CHECK: begin
            if (found) begin
               if (op_ff == skhc_pkg::OP_MARK) begin
                  wr_en = 1'b1;
                  wr_data[CNT_LSB +: skhc_pkg::COUNT_W] = inc_count;
               end else if (op_ff == skhc_pkg::OP_UNMARK) begin
                  wr_en = 1'b1;
                  wr_data[MODE_LSB +: 2] = skhc_pkg::MODE_TOMB;
               end
            end else if (stop_empty && (op_ff == skhc_pkg::OP_MARK)) begin
               // new key lands in the first empty slot
               wr_en   = 1'b1;
               wr_data = {skhc_pkg::MODE_LIVE, skhc_pkg::COUNT_W'(1), len_ff, key_ff};
            end
         end
         default: req_stall = 1'b1;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ts_ff        <= skhc_pkg::TS_CLEAR;
         idx_ff       <= '0;
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ts_ff <= ts_in;
         case (ts_ff)
            skhc_pkg::TS_CLEAR: idx_ff <= idx_next;
            skhc_pkg::TS_HASH: if (hash_done) idx_ff <= hash_home;
            skhc_pkg::TS_CHECK: begin
               if (!found && !stop_empty) idx_ff <= idx_next;
               if (found && (op_ff == skhc_pkg::OP_UNMARK) && (live_ff != '0)) begin
                  live_ff <= live_ff - 1'b1;
               end else if (!found && stop_empty && (op_ff == skhc_pkg::OP_MARK)) begin
                  live_ff <= live_ff + 1'b1;
               end
            end
            default: idx_ff <= idx_ff;
         endcase
         // output register: load on leaving resp, drop once taken
         if ((ts_ff == skhc_pkg::TS_RESP) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff         <= req_opcode;
         key_ff        <= key_masked;
         len_ff        <= len_eff;
         res_status_ff <= (req_opcode == skhc_pkg::OP_NOP)
                          ? skhc_pkg::ST_DONE : skhc_pkg::ST_FULL;
         res_hit_ff    <= '0;
      end
      if (ts_ff == skhc_pkg::TS_HASH) begin
         probe_ff <= '0;
      end else if (ts_ff == skhc_pkg::TS_CHECK) begin
         probe_ff <= probe_ff + 1'b1;
         if (found) begin
            res_status_ff <= skhc_pkg::ST_DONE;
            case (op_ff)
               skhc_pkg::OP_MARK:  res_hit_ff <= inc_count;
               skhc_pkg::OP_COUNT: res_hit_ff <= rd_count;
               default:            res_hit_ff <= '0;
            endcase
         end else if (stop_empty) begin
            if (op_ff == skhc_pkg::OP_MARK) begin
               res_status_ff <= skhc_pkg::ST_DONE;
               res_hit_ff    <= skhc_pkg::COUNT_W'(1);
            end else begin
               res_status_ff <= skhc_pkg::ST_ABSENT;
            end
         end else if (wrapped) begin
            res_status_ff <= (op_ff == skhc_pkg::OP_MARK)
                             ? skhc_pkg::ST_FULL : skhc_pkg::ST_ABSENT;
         end
      end
      if ((ts_ff == skhc_pkg::TS_RESP) && out_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_hit_ff    <= res_hit_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_hit_count = rsp_hit_ff;

endmodule

### hw/rtl/skhc_ram.sv
`timescale 1ns / 1ps
module skhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/skhc_hash.sv
`timescale 1ns / 1ps
module skhc_hash #(
   parameter int TABLE_SLOTS   = 64,
   parameter int MAX_KEY_BYTES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [8*MAX_KEY_BYTES-1:0]          key,
   input  logic [skhc_pkg::KEY_LEN_W-1:0]      key_length,
   output logic                                done,
   output logic [$clog2(TABLE_SLOTS)-1:0]      home
);

   localparam int KEY_W = 8 * MAX_KEY_BYTES;
   localparam int IDX_W = $clog2(TABLE_SLOTS);
   localparam int BIT_W = $clog2(skhc_pkg::HASH_W);

   skhc_pkg::hash_state_type hs_ff, hs_in;

   logic [KEY_W-1:0]                   key_sr_ff;
   logic [skhc_pkg::KEY_LEN_W-1:0]     left_ff;
   logic [skhc_pkg::HASH_W-1:0]        h_ff;
   logic [skhc_pkg::HASH_W-1:0]        base_ff;
   logic [2:0]                         term_ff;
   logic [IDX_W-1:0]                   rem_ff;
   logic [BIT_W-1:0]                   bit_ff;

   logic [skhc_pkg::HASH_W-1:0]        mixed;
   logic [IDX_W:0]                     rem_wide;
   logic [IDX_W:0]                     rem_red;
   logic                               last_term;
   logic                               last_bit;

   assign mixed     = h_ff ^ {{(skhc_pkg::HASH_W-8){1'b0}}, key_sr_ff[7:0]};
   assign last_term = (term_ff == 3'(skhc_pkg::MUL_TERMS - 1));
   assign last_bit  = (bit_ff == BIT_W'(skhc_pkg::HASH_W - 1));

   // one remainder bit per cycle, msb first
   assign rem_wide = {rem_ff, h_ff[skhc_pkg::HASH_W-1]};
   assign rem_red  = (rem_wide >= (IDX_W+1)'(TABLE_SLOTS))
                     ? rem_wide - (IDX_W+1)'(TABLE_SLOTS) : rem_wide;

   // next state
   always_comb begin
      hs_in = hs_ff;
      case (hs_ff)
         skhc_pkg::HS_IDLE: if (start) hs_in = skhc_pkg::HS_XOR;
         skhc_pkg::HS_XOR: begin
            if (left_ff == '0) hs_in = skhc_pkg::HS_MOD;
            else hs_in = skhc_pkg::HS_MUL;
         end
         skhc_pkg::HS_MUL: if (last_term) hs_in = skhc_pkg::HS_XOR;
         skhc_pkg::HS_MOD: if (last_bit) hs_in = skhc_pkg::HS_IDLE;
         default: hs_in = skhc_pkg::HS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = 1'b0;
      home = rem_red[IDX_W-1:0];
      case (hs_ff)
         skhc_pkg::HS_MOD: done = last_bit;
         default: done = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff <= skhc_pkg::HS_IDLE;
      end else begin
         hs_ff <= hs_in;
      end
   end

   always_ff @(posedge clock) begin
      case (hs_ff)
         skhc_pkg::HS_IDLE: begin
            key_sr_ff <= key;
            left_ff   <= key_length;
            h_ff      <= skhc_pkg::FNV_BASIS;
            rem_ff    <= '0;
            bit_ff    <= '0;
         end
         skhc_pkg::HS_XOR: begin
            if (left_ff != '0) begin
               h_ff      <= mixed;
               base_ff   <= mixed;
               term_ff   <= '0;
               key_sr_ff <= key_sr_ff >> 8;
               left_ff   <= left_ff - 1'b1;
            end
         end
         skhc_pkg::HS_MUL: begin
            h_ff    <= h_ff + (base_ff << skhc_pkg::MUL_SHIFT[term_ff]);
            term_ff <= term_ff + 1'b1;
         end
         skhc_pkg::HS_MOD: begin
            rem_ff <= rem_red[IDX_W-1:0];
            h_ff   <= h_ff << 1;
            bit_ff <= bit_ff + 1'b1;
         end
         default: begin
            bit_ff <= '0;
         end
      endcase
   end

endmodule

### bench/string_key_counting_hash_table_unit_tb.sv
`timescale 1ns / 1ps
module string_key_counting_hash_table_unit_tb;
   import skhc_pkg::*;

   localparam int SLOTS     = 64;
   localparam int KEY_BYTES = 16;
   localparam longint unsigned CYCLE_LIMIT = 4000000;

   typedef struct {
      logic [1:0]           opcode;
      logic [63:0]          key_lo;
      logic [63:0]          key_hi;
      logic [KEY_LEN_W-1:0] key_len;
   } table_op_t;

   typedef struct {
      logic [1:0]         status;
      logic [COUNT_W-1:0] hits;
   } table_reply_t;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [1:0]           req_opcode;
   logic [63:0]          req_key_low_bytes;
   logic [63:0]          req_key_high_bytes;
   logic [KEY_LEN_W-1:0] req_key_length;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [1:0]           rsp_status;
   logic [COUNT_W-1:0]   rsp_hit_count;

   string_key_counting_hash_table_unit #(
      .TABLE_SLOTS(SLOTS),
      .MAX_KEY_BYTES(KEY_BYTES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_opcode(req_opcode),
      .req_key_low_bytes(req_key_low_bytes),
      .req_key_high_bytes(req_key_high_bytes),
      .req_key_length(req_key_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_status(rsp_status),
      .rsp_hit_count(rsp_hit_count)
   );

   // shadow copy of the table
   logic [1:0]           shadow_mode [SLOTS];
   logic [127:0]         shadow_key [SLOTS];
   logic [KEY_LEN_W-1:0] shadow_len [SLOTS];
   logic [COUNT_W-1:0]   shadow_count [SLOTS];
   int                   shadow_live;

   table_op_t    pending_ops [$];
   table_reply_t expected_replies [$];

   // traffic shaping knobs, percent of cycles that each side idles
   int  send_idle_pct;
   int  recv_idle_pct;
   int  recv_hold;        // remaining cycles of a long receive hold-off
   bit  send_pause;       // driver waits for all replies to drain
   int  error_count;
   longint unsigned cycle_count;

   // key pool so random ops hit existing entries often
   logic [127:0]         pool_key [12];
   logic [KEY_LEN_W-1:0] pool_len [12];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [63:0] fnv_hash(logic [127:0] k, int n);
      logic [63:0] h;
      h = 64'hcbf29ce484222325;
      for (int i = 0; i < n; i++) begin
         h = h ^ {56'd0, k[8*i +: 8]};
         h = h * 64'd1099511628211;
      end
      return h;
   endfunction

   // returns 1 at a match, 0 at the first empty slot, -1 after a full wrap
   function automatic int find_slot(logic [127:0] k, int n, output int at);
      int idx;
      idx = int'(fnv_hash(k, n) % SLOTS);
      at = 0;
      for (int p = 0; p < SLOTS; p++) begin
         if (shadow_mode[idx] == MODE_LIVE) begin
            if (shadow_len[idx] == n && shadow_key[idx] == k) begin
               at = idx;
               return 1;
            end
         end else if (shadow_mode[idx] != MODE_TOMB) begin
            at = idx;
            return 0;
         end
         idx = (idx + 1) % SLOTS;
      end
      return -1;
   endfunction

   function automatic table_reply_t apply_table_op(table_op_t op);
      table_reply_t r;
      int           n;
      int           at;
      int           found;
      logic [127:0] k;
      r.status = ST_DONE;
      r.hits   = '0;
      n = (op.key_len > KEY_BYTES) ? KEY_BYTES : int'(op.key_len);
      k = {op.key_hi, op.key_lo};
      for (int b = 0; b < 16; b++)
         if (b >= n) k[8*b +: 8] = 8'd0;
      case (op.opcode)
         OP_MARK: begin
            if (4 * (shadow_live + 1) > 3 * SLOTS) begin
               r.status = ST_FULL;
            end else begin
               found = find_slot(k, n, at);
               if (found < 0) begin
                  r.status = ST_FULL;
               end else begin
                  if (found == 0) begin
                     shadow_mode[at]  = MODE_LIVE;
                     shadow_key[at]   = k;
                     shadow_len[at]   = KEY_LEN_W'(n);
                     shadow_count[at] = '0;
                     shadow_live++;
                  end
                  if (shadow_count[at] != COUNT_MAX) shadow_count[at]++;
                  r.hits = shadow_count[at];
               end
            end
         end
         OP_UNMARK: begin
            found = find_slot(k, n, at);
            if (found == 1) begin
               shadow_mode[at] = MODE_TOMB;
               if (shadow_live > 0) shadow_live--;
            end else begin
               r.status = ST_ABSENT;
            end
         end
         OP_COUNT: begin
            found = find_slot(k, n, at);
            if (found == 1) r.hits = shadow_count[at];
            else r.status = ST_ABSENT;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic table_op_t make_op(logic [1:0] opc, logic [127:0] k, int n);
      table_op_t op;
      op.opcode  = opc;
      op.key_lo  = k[63:0];
      op.key_hi  = k[127:64];
      op.key_len = KEY_LEN_W'(n);
      return op;
   endfunction

   function automatic logic [127:0] rand_key();
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   // a random op: mostly pool keys with zero padding, some junk bytes past length
   function automatic table_op_t random_op();
      logic [127:0] k;
      int           n;
      int           sel;
      int           pick;
      logic [1:0]   opc;
      sel = $urandom_range(99);
      if (sel < 45) opc = OP_MARK;
      else if (sel < 65) opc = OP_UNMARK;
      else if (sel < 95) opc = OP_COUNT;
      else opc = OP_NOP;
      if ($urandom_range(99) < 75) begin
         pick = $urandom_range(11);
         k = pool_key[pick];
         n = int'(pool_len[pick]);
         // garbage beyond the key length must be ignored
         if ($urandom_range(3) == 0)
            for (int b = 0; b < 16; b++)
               if (b >= n) k[8*b +: 8] = 8'($urandom);
         if (n == KEY_BYTES && $urandom_range(3) == 0) n = $urandom_range(31, 17);
      end else begin
         k = rand_key();
         n = $urandom_range(31);
         if ($urandom_range(3) == 0) n = $urandom_range(3);
      end
      return make_op(opc, k, n);
   endfunction

   // driver: offers queued ops, idles at random or on a drain pause
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_replies.push_back(apply_table_op(pending_ops.pop_front()));
         end
         // hold a stalled beat steady
         if (!(req_valid && req_stall)) begin
            if (pending_ops.size() > 0 && !send_pause &&
                $urandom_range(99) >= send_idle_pct) begin
               req_valid          <= 1'b1;
               req_opcode         <= pending_ops[0].opcode;
               req_key_low_bytes  <= pending_ops[0].key_lo;
               req_key_high_bytes <= pending_ops[0].key_hi;
               req_key_length     <= pending_ops[0].key_len;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver stall, with a long hold-off counted here
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (recv_hold > 0) begin
         recv_hold <= recv_hold - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // monitor: check every response beat against the oldest expectation
   always @(posedge clock) begin
      table_reply_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_replies.size() == 0) begin
            $error("unexpected response beat status=%0d hit_count=%0d",
                   rsp_status, rsp_hit_count);
            error_count++;
         end else begin
            want = expected_replies.pop_front();
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               error_count++;
            end
            if (rsp_hit_count !== want.hits) begin
               $error("hit_count expected %0d actual %0d", want.hits, rsp_hit_count);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_ops.size() > 0 || req_valid || expected_replies.size() > 0)
         @(posedge clock);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) pending_ops.push_back(random_op());
      while (pending_ops.size() > 0) @(posedge clock);
   endtask

   initial begin
      logic [127:0] k;
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_opcode         = OP_NOP;
      req_key_low_bytes  = '0;
      req_key_high_bytes = '0;
      req_key_length     = '0;
      rsp_stall          = 1'b0;
      send_idle_pct      = 0;
      recv_idle_pct      = 0;
      recv_hold          = 0;
      send_pause         = 1'b0;
      error_count        = 0;
      cycle_count        = 0;
      shadow_live        = 0;
      for (int s = 0; s < SLOTS; s++) begin
         shadow_mode[s]  = MODE_EMPTY;
         shadow_key[s]   = '0;
         shadow_len[s]   = '0;
         shadow_count[s] = '0;
      end
      for (int p = 0; p < 12; p++) begin
         pool_len[p] = (p < 2) ? KEY_LEN_W'(p) : KEY_LEN_W'($urandom_range(KEY_BYTES));
         pool_key[p] = rand_key();
         for (int b = 0; b < 16; b++)
            if (b >= pool_len[p]) pool_key[p][8*b +: 8] = 8'd0;
      end
      pool_len[11] = KEY_LEN_W'(KEY_BYTES);
      pool_key[11] = rand_key();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: empty key, full length keys, overlong length, absent keys, nop
      pending_ops.push_back(make_op(OP_COUNT, '0, 0));
      pending_ops.push_back(make_op(OP_UNMARK, '0, 0));
      pending_ops.push_back(make_op(OP_MARK, '0, 0));
      pending_ops.push_back(make_op(OP_MARK, {128{1'b1}}, 0));
      pending_ops.push_back(make_op(OP_COUNT, '0, 0));
      pending_ops.push_back(make_op(OP_MARK, {128{1'b1}}, 16));
      pending_ops.push_back(make_op(OP_MARK, {128{1'b1}}, 31));
      pending_ops.push_back(make_op(OP_COUNT, {128{1'b1}}, 16));
      pending_ops.push_back(make_op(OP_MARK, {128{1'b1}}, 8));
      pending_ops.push_back(make_op(OP_MARK, 128'hff, 1));
      pending_ops.push_back(make_op(OP_COUNT, 128'h1ff, 1));
      pending_ops.push_back(make_op(OP_UNMARK, {128{1'b1}}, 16));
      pending_ops.push_back(make_op(OP_COUNT, {128{1'b1}}, 17));
      pending_ops.push_back(make_op(OP_UNMARK, {128{1'b1}}, 16));
      pending_ops.push_back(make_op(OP_MARK, {128{1'b1}}, 16));
      pending_ops.push_back(make_op(OP_NOP, {128{1'b1}}, 31));
      pending_ops.push_back(make_op(OP_COUNT, 128'h0, 9));
      while (pending_ops.size() > 0) @(posedge clock);
      wait_drained();

      // fill to the load limit with distinct keys, then refuse even known keys
      send_idle_pct = 22;
      recv_idle_pct = 52;
      for (int i = 0; i < 60; i++) begin
         k = rand_key();
         pending_ops.push_back(make_op(OP_MARK, k, $urandom_range(1, 16)));
      end
      pending_ops.push_back(make_op(OP_MARK, '0, 0));
      // long receive hold-off while ops keep coming so the input backs up
      recv_hold = 600;
      while (pending_ops.size() > 0) @(posedge clock);
      // empty the table again through tombstones, then tombstone-heavy probes
      wait_drained();
      for (int s = 0; s < SLOTS; s++)
         if (shadow_mode[s] == MODE_LIVE)
            pending_ops.push_back(make_op(OP_UNMARK, shadow_key[s], int'(shadow_len[s])));
      queue_random(0);
      // once all slots are live or tombstones, marks of new keys wrap and fail
      for (int i = 0; i < 40; i++) pending_ops.push_back(make_op(OP_MARK, rand_key(), 16));
      queue_random(500);

      // sender pauses until every reply is back
      send_pause = 1'b1;
      while (expected_replies.size() > 0 || req_valid) @(posedge clock);
      send_pause = 1'b0;

      send_idle_pct = 52;
      recv_idle_pct = 22;
      queue_random(500);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(500);

      wait_drained();
      repeat (400) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
